/* design/u64cmd_pkg.sv */
// u64cmd_pkg: commands, widths and pipeline types for uint64_carry_mul_div_unit.
// No dependencies.
`default_nettype none
package u64cmd_pkg;
	localparam int unsigned W = 64;
	localparam int unsigned DIV_STEPS_PER_STAGE = 4;

	typedef enum logic [3:0] {
		CMD_CMP    = 4'd0,
		CMD_ADD    = 4'd1,
		CMD_ADC    = 4'd2,
		CMD_SUB    = 4'd3,
		CMD_SBB    = 4'd4,
		CMD_MUL    = 4'd5,
		CMD_DIV128 = 4'd6,
		CMD_DIVMOD = 4'd7,
		CMD_MOD    = 4'd8
	} cmd_t;

	localparam logic [1:0] ORD_EQ = 2'd0;
	localparam logic [1:0] ORD_LT = 2'd1;
	localparam logic [1:0] ORD_GT = 2'd2;

	typedef struct packed {
		logic [W-1:0] hi;
		logic [W-1:0] lo;
		logic         carry;
		logic [1:0]   ord;
		logic         err;
	} result_t;

	// Divider working set.
	typedef struct packed {
		logic [W-1:0] rem;
		logic [W-1:0] num;   // remaining dividend bits, MSB first; quotient shifts in
		logic [W-1:0] den;
	} div_t;
endpackage
`default_nettype wire

/* design/u64cmd_if.sv */
// u64cmd_if: valid/ready channel carrying a request or a result.
// Depends on u64cmd_pkg.
`default_nettype none
interface u64cmd_req_if;
	logic                  valid;
	logic                  ready;
	logic [3:0]            cmd;
	logic [u64cmd_pkg::W-1:0] operand_a;
	logic [u64cmd_pkg::W-1:0] operand_b;
	logic [u64cmd_pkg::W-1:0] operand_c;
	modport source (output valid, cmd, operand_a, operand_b, operand_c, input ready);
	modport sink (input valid, cmd, operand_a, operand_b, operand_c, output ready);
endinterface

interface u64cmd_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [u64cmd_pkg::W-1:0] result_high;
	logic [u64cmd_pkg::W-1:0] result_low;
	logic                     carry_flag;
	logic [1:0]               order;
	logic                     error;
	modport source (output valid, result_high, result_low, carry_flag, order, error,
		input ready);
	modport sink (input valid, result_high, result_low, carry_flag, order, error,
		output ready);
endinterface
`default_nettype wire

/* design/u64cmd_div_stage.sv */
// u64cmd_div_stage: STEPS combinational restoring-division steps, no registers.
// Depends on u64cmd_pkg.
`default_nettype none
module u64cmd_div_stage #(
	parameter int unsigned STEPS = u64cmd_pkg::DIV_STEPS_PER_STAGE
) (
	input  var u64cmd_pkg::div_t d_in,
	output u64cmd_pkg::div_t d_out
);
	import u64cmd_pkg::*;

	always_comb begin
		logic [W:0] sh;
		d_out = d_in;
		for (int i = 0; i < STEPS; i++) begin
			sh = {d_out.rem, d_out.num[W-1]};
			d_out.num = {d_out.num[W-2:0], 1'b0};
			if (sh >= {1'b0, d_out.den}) begin
				sh = sh - {1'b0, d_out.den};
				d_out.num[0] = 1'b1;
			end
			d_out.rem = sh[W-1:0];
		end
	end
endmodule
`default_nettype wire

/* design/u64cmd_mul.sv */
// u64cmd_mul: 64x64 multiply from four registered 32x32 partial products.
// Depends on u64cmd_pkg. Products are registered; the summation is combinational.
`default_nettype none
module u64cmd_mul (
	input  var logic                  clk,
	input  var logic                  en,
	input  var logic [u64cmd_pkg::W-1:0] a,
	input  var logic [u64cmd_pkg::W-1:0] b,
	output logic [2*u64cmd_pkg::W-1:0]   prod
);
	import u64cmd_pkg::*;
	localparam int unsigned H = W / 2;

	logic [W-1:0] p0_s1, p1_s1, p2_s1, p3_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= W'(a[H-1:0]) * W'(b[H-1:0]);
			p1_s1 <= W'(a[H-1:0]) * W'(b[W-1:H]);
			p2_s1 <= W'(a[W-1:H]) * W'(b[H-1:0]);
			p3_s1 <= W'(a[W-1:H]) * W'(b[W-1:H]);
		end
	end

	assign prod = {p3_s1, p0_s1} + ({{H{1'b0}}, p1_s1, {H{1'b0}}})
		+ ({{H{1'b0}}, p2_s1, {H{1'b0}}});
endmodule
`default_nettype wire

/* design/uint64_carry_mul_div_unit.sv */
// Unsigned 64-bit arithmetic unit: compare, add/sub with carry, 64x64->128
// multiply, 128/64 and 64/64 division. Fully pipelined: one request per cycle
// while not stalled. With the default of four restoring steps per stage, a
// request passes 16 divider registers, the first fed straight from the request,
// then the multiplier product register and the output register. The whole pipe
// advances together; it stalls only when the output register holds a result
// that is not taken. Division errors (zero divisor, or high word not below the
// divisor for 128/64) give error=1 and zero values.
// Depends on u64cmd_pkg, u64cmd_if.
`default_nettype none
module uint64_carry_mul_div_unit #(
	parameter int unsigned DIV_STEPS = u64cmd_pkg::DIV_STEPS_PER_STAGE
) (
	input  var logic clk,
	input  var logic arst_n,
	u64cmd_req_if.sink   req,
	u64cmd_rsp_if.source rsp
);
	import u64cmd_pkg::*;
	localparam int unsigned NST = W / DIV_STEPS;

	typedef struct packed {
		logic [3:0] cmd;
		logic       err;
		result_t    quick;   // result of non-division commands
	} tag_t;

	logic adv;
	logic [NST+1:0] vld_q;
	tag_t tag_s;
	div_t dv_s;
	div_t dv_n [NST];
	logic [2*W-1:0] prod;
	logic [W-1:0] a_s1, b_s1;
	result_t fin;

	assign adv = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	// Entry stage: simple ops, division setup.
	always_comb begin
		tag_t t;
		div_t d;
		logic [W:0] s;
		t = '0;
		d = '0;
		t.cmd = req.cmd;
		s = '0;
		unique case (req.cmd)
			CMD_CMP: t.quick.ord = (req.operand_a < req.operand_b) ? ORD_LT :
				((req.operand_a > req.operand_b) ? ORD_GT : ORD_EQ);
			CMD_ADD, CMD_ADC: begin
				s = {1'b0, req.operand_a} + {1'b0, req.operand_b}
					+ {{W{1'b0}}, (req.cmd == CMD_ADC)};
				t.quick.lo = s[W-1:0];
				t.quick.carry = s[W];
			end
			CMD_SUB, CMD_SBB: begin
				s = {1'b0, req.operand_a} - {1'b0, req.operand_b}
					- {{W{1'b0}}, (req.cmd == CMD_SBB)};
				t.quick.lo = s[W-1:0];
				t.quick.carry = s[W];
			end
			CMD_DIV128: begin
				t.err = (req.operand_c == '0) || (req.operand_a >= req.operand_c);
				d.rem = req.operand_a;
				d.num = req.operand_b;
				d.den = req.operand_c;
			end
			CMD_DIVMOD, CMD_MOD: begin
				t.err = (req.operand_b == '0);
				d.num = req.operand_a;
				d.den = req.operand_b;
			end
			default: ;
		endcase
		tag_s = t;
		dv_s = d;
	end

	tag_t tag_q [NST];
	div_t dv_q [NST];

	genvar g;
	generate
		for (g = 0; g < NST; g++) begin : g_div
			if (g == 0) begin : g_head
				u64cmd_div_stage #(.STEPS(DIV_STEPS)) u_st (
					.d_in (dv_s),
					.d_out(dv_n[g])
				);
				always_ff @(posedge clk) begin
					if (adv) begin
						dv_q[g] <= dv_n[g];
						tag_q[g] <= tag_s;
					end
				end
			end else begin : g_tail
				u64cmd_div_stage #(.STEPS(DIV_STEPS)) u_st (
					.d_in (dv_q[g-1]),
					.d_out(dv_n[g])
				);
				always_ff @(posedge clk) begin
					if (adv) begin
						dv_q[g] <= dv_n[g];
						tag_q[g] <= tag_q[g-1];
					end
				end
			end
		end
	endgenerate

	// Multiplier operands ride the pipe until the last stage.
	logic [W-1:0] ma_q [NST];
	logic [W-1:0] mb_q [NST];
	always_ff @(posedge clk) begin
		if (adv) begin
			ma_q[0] <= req.operand_a;
			mb_q[0] <= req.operand_b;
			for (int i = 1; i < NST; i++) begin
				ma_q[i] <= ma_q[i-1];
				mb_q[i] <= mb_q[i-1];
			end
		end
	end
	assign a_s1 = ma_q[NST-1];
	assign b_s1 = mb_q[NST-1];

	tag_t tag_m;
	div_t dv_m;
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_m <= tag_q[NST-1];
			dv_m <= dv_q[NST-1];
		end
	end

	u64cmd_mul u_mul (.clk(clk), .en(adv), .a(a_s1), .b(b_s1), .prod(prod));

	always_comb begin
		fin = tag_m.quick;
		if (tag_m.err) begin
			fin = '0;
			fin.err = 1'b1;
		end else begin
			unique case (tag_m.cmd)
				CMD_MUL: begin
					fin.hi = prod[2*W-1:W];
					fin.lo = prod[W-1:0];
				end
				CMD_DIV128, CMD_DIVMOD: begin
					fin.hi = dv_m.num;
					fin.lo = dv_m.rem;
				end
				CMD_MOD: fin.lo = dv_m.rem;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST:0], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp.result_high <= fin.hi;
			rsp.result_low <= fin.lo;
			rsp.carry_flag <= fin.carry;
			rsp.order <= fin.ord;
			rsp.error <= fin.err;
		end
	end
	assign rsp.valid = vld_q[NST+1];

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error |-> rsp.result_high == '0 && rsp.result_low == '0)
		else $error("error result carries value");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.order != ORD_EQ |-> !rsp.carry_flag && !rsp.error)
		else $error("compare result mixed with other flags");
endmodule
`default_nettype wire
